FILE: design/assert_macros.svh
// Assertion macros used by the port checker of the window coefficient generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: design/wcg_pkg.sv
// Package with the types, constants, weights and cosine table function of the window generator.
package wcg_pkg;

  localparam int unsigned INDEX_BITS_DEF     = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;
  localparam int unsigned COS_TABLE_BITS_DEF = 10;

  localparam int unsigned TYPE_W      = 4;
  localparam int unsigned SIZE_W      = 17;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned COS_W       = 31;
  localparam int unsigned PROD_W      = 62;
  localparam int unsigned DIV_QW      = 33;
  localparam int unsigned DIV_RW      = 2 * SIZE_W + 1;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TYPE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 1'b1;

  localparam logic [TYPE_W-1:0] TYPE_WELCH    = 4'd8;
  localparam logic [TYPE_W-1:0] NUM_COS_TYPES = 4'd8;

  localparam logic [TYPE_W-1:0] TYPE_RESET = 4'd0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd1024;

  localparam logic [63:0] Q31 = 64'd2147483648;

  typedef struct packed {
    logic valid;
    logic err;
  } wcg_tag_t;

  localparam logic [COS_W-1:0] WEIGHTS [8][5] = '{
    '{31'd1073741824, 31'd0, 31'd0, 31'd0, 31'd0},
    '{31'((64'd25 * Q31 + 64'd46) / 64'd92),
      31'((64'd21 * Q31 + 64'd46) / 64'd92), 31'd0, 31'd0, 31'd0},
    '{31'd536870912, 31'd536870912, 31'd0, 31'd0, 31'd0},
    '{31'((64'd7938 * Q31 + 64'd18608) / 64'd37216),
      31'((64'd9240 * Q31 + 64'd18608) / 64'd37216),
      31'((64'd1430 * Q31 + 64'd18608) / 64'd37216), 31'd0, 31'd0},
    '{31'((64'd355768 * Q31 + 64'd1000000) / 64'd2000000),
      31'((64'd487396 * Q31 + 64'd1000000) / 64'd2000000),
      31'((64'd144232 * Q31 + 64'd1000000) / 64'd2000000),
      31'((64'd12604 * Q31 + 64'd1000000) / 64'd2000000), 31'd0},
    '{31'((64'd3635819 * Q31 + 64'd10000000) / 64'd20000000),
      31'((64'd4891775 * Q31 + 64'd10000000) / 64'd20000000),
      31'((64'd1365995 * Q31 + 64'd10000000) / 64'd20000000),
      31'((64'd106411 * Q31 + 64'd10000000) / 64'd20000000), 31'd0},
    '{31'((64'd35875 * Q31 + 64'd100000) / 64'd200000),
      31'((64'd48829 * Q31 + 64'd100000) / 64'd200000),
      31'((64'd14128 * Q31 + 64'd100000) / 64'd200000),
      31'((64'd1168 * Q31 + 64'd100000) / 64'd200000), 31'd0},
    '{31'((64'd215578950 * Q31 + 64'd1000000000) / 64'd2000000000),
      31'((64'd416631580 * Q31 + 64'd1000000000) / 64'd2000000000),
      31'((64'd277263158 * Q31 + 64'd1000000000) / 64'd2000000000),
      31'((64'd83578947 * Q31 + 64'd1000000000) / 64'd2000000000),
      31'((64'd6947368 * Q31 + 64'd1000000000) / 64'd2000000000)}
  };

  // Quarter-wave cosine entry in Q30, evaluated at elaboration time.
  function automatic logic [COS_W-1:0] quarter_cos(input int unsigned j,
                                                   input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'd1686629713 * 64'(j) + (64'd1 << (tbits - 1))) >> tbits;
    x2   = (x * x) >> 30;
    term = 64'd1073741824;
    sum  = 64'sd1073741824;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    return COS_W'(sum);
  endfunction

endpackage

FILE: design/wcg_div_pipe.sv
// Pipelined restoring divider that produces one quotient bit per stage.
module wcg_div_pipe #(
  parameter int unsigned QW = 33,
  parameter int unsigned RW = 35
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  wcg_pkg::wcg_tag_t tag_i,
  input  logic [RW-1:0]     rem_i,
  input  logic [QW-1:0]     bits_i,
  input  logic [RW-1:0]     divisor_i,
  output wcg_pkg::wcg_tag_t tag_o,
  output logic [QW-1:0]     quo_o
);
  import wcg_pkg::*;

  wcg_tag_t      tag_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [RW-1:0] rem_q  [QW-1];
  logic [QW-1:0] bits_q [QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    wcg_tag_t      tag_in;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] bits_in;
    logic [QW-1:0] quo_in;
    logic [RW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign tag_in  = tag_i;
      assign rem_in  = rem_i;
      assign bits_in = bits_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign tag_in  = tag_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign bits_in = bits_q[s-1];
      assign quo_in  = quo_q[s-1];
    end

    assign trial = {rem_in, bits_in[QW-1]};
    assign ge    = trial >= {1'b0, divisor_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= {quo_in[QW-2:0], ge};
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s]  <= ge ? RW'(trial - {1'b0, divisor_i}) : trial[RW-1:0];
          bits_q[s] <= {bits_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign tag_o = tag_q[QW-1];
  assign quo_o = quo_q[QW-1];

endmodule

FILE: design/wcg_cos_rom.sv
// Quarter-wave cosine ROM in Q30 with a registered read port.
module wcg_cos_rom #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [TABLE_BITS:0]         addr_i,
  output logic [wcg_pkg::COS_W-1:0]   data_o
);
  import wcg_pkg::*;

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  logic [COS_W-1:0] rom [DEPTH];
  logic [COS_W-1:0] data_q;

  for (genvar j = 0; j < DEPTH; j++) begin : g_rom
    localparam logic [COS_W-1:0] ENTRY = quarter_cos(j, TABLE_BITS);
    assign rom[j] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

FILE: design/wcg_post.sv
// Phase rounding, cosine lookup, weighted cosine sum and output selection stages.
module wcg_post #(
  parameter int unsigned COS_TABLE_BITS = 10,
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [wcg_pkg::TYPE_W-1:0]       window_type_i,
  input  wcg_pkg::wcg_tag_t                tag_i,
  input  logic [wcg_pkg::DIV_QW-1:0]       quo_i,
  output wcg_pkg::wcg_tag_t                tag_o,
  output logic signed [COEF_FRAC_BITS+1:0] coef_o
);
  import wcg_pkg::*;

  localparam int unsigned QW  = COEF_FRAC_BITS + 2;
  localparam int unsigned SH  = PHASE_W - (COS_TABLE_BITS + 2);
  localparam int unsigned AW  = COS_TABLE_BITS + 1;
  localparam int unsigned M   = 1 << COS_TABLE_BITS;
  localparam int unsigned S   = 60 - COEF_FRAC_BITS;
  localparam logic [PHASE_W-1:0] HALF_TURN = PHASE_W'(1) << (SH - 1);
  localparam logic signed [63:0] HALF_SUM  = 64'sd1 <<< (S - 1);
  localparam longint HI = (longint'(1) << (COEF_FRAC_BITS + 1)) - 1;
  localparam longint LO = -(longint'(1) << (COEF_FRAC_BITS + 1));
  localparam logic [COS_W-1:0] COS0 = quarter_cos(0, COS_TABLE_BITS);

  wcg_tag_t           tag_q   [9];
  logic [QW-1:0]      welch_q [8];
  logic [PHASE_W-1:0] ph_q;
  logic [PHASE_W-1:0] turn_q  [4];
  logic [AW-1:0]      addr_q  [4];
  logic               neg3_q  [4];
  logic               neg4_q  [4];
  logic [COS_W-1:0]   cos_w   [4];
  logic [PROD_W-1:0]  prod_q  [5];
  logic               sign_q  [5];
  logic signed [63:0] ta_q, tb_q, tc_q, tab_q, tc7_q, sum_q;
  logic signed [COEF_FRAC_BITS+1:0] coef_q;

  logic [DIV_QW:0]    ph_sum;
  logic [PHASE_W-1:0] turn_d  [4];
  logic [AW-1:0]      addr_d  [4];
  logic               neg_d   [4];
  logic [COS_W-1:0]   wt      [5];
  logic [PROD_W-1:0]  prod_d  [5];
  logic               sign_d  [5];
  logic signed [63:0] sp      [5];
  logic signed [63:0] shifted;
  logic signed [63:0] val;
  logic               cos_type;

  assign ph_sum = {1'b0, quo_i} + (DIV_QW + 1)'(1);

  assign turn_d[0] = ph_q;
  assign turn_d[1] = {ph_q[PHASE_W-2:0], 1'b0};
  assign turn_d[2] = ph_q + turn_d[1];
  assign turn_d[3] = {ph_q[PHASE_W-3:0], 2'b00};

  assign cos_type = window_type_i < NUM_COS_TYPES;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [PHASE_W-1:0]          idx_full;
    logic [1:0]                  quad;
    logic [COS_TABLE_BITS-1:0]   r;
    localparam logic ODD = ((k + 1) % 2) == 1;

    assign idx_full  = turn_q[k] + HALF_TURN;
    assign quad      = idx_full[PHASE_W-1 -: 2];
    assign r         = idx_full[SH +: COS_TABLE_BITS];
    assign addr_d[k] = quad[0] ? (AW'(M) - {1'b0, r}) : {1'b0, r};
    assign neg_d[k]  = quad[1] ^ quad[0];

    wcg_cos_rom #(
      .TABLE_BITS(COS_TABLE_BITS)
    ) u_rom (
      .clk_i (clk_i),
      .en_i  (en_i),
      .addr_i(addr_q[k]),
      .data_o(cos_w[k])
    );

    assign prod_d[k+1] = PROD_W'(wt[k+1]) * PROD_W'(cos_w[k]);
    assign sign_d[k+1] = neg4_q[k] ^ ODD;
  end

  for (genvar k = 0; k < 5; k++) begin : g_term
    assign wt[k] = cos_type ? WEIGHTS[window_type_i[2:0]][k] : '0;
    assign sp[k] = sign_q[k] ? -$signed(64'(prod_q[k])) : $signed(64'(prod_q[k]));
  end

  assign prod_d[0] = PROD_W'(wt[0]) * PROD_W'(COS0);
  assign sign_d[0] = 1'b0;

  assign shifted = sum_q >>> S;

  always_comb begin
    priority if (tag_q[7].err) begin
      val = '0;
    end else if (window_type_i == TYPE_WELCH) begin
      val = $signed(64'(welch_q[7]));
    end else if (cos_type) begin
      val = shifted;
    end else begin
      val = '0;
    end
    if (val > HI) begin
      val = HI;
    end
    if (val < LO) begin
      val = LO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 9; s++) begin
        tag_q[s] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < 9; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q       <= ph_sum[PHASE_W:1];
      welch_q[0] <= quo_i[DIV_QW-1 -: QW];
      for (int s = 1; s < 8; s++) begin
        welch_q[s] <= welch_q[s-1];
      end
      for (int k = 0; k < 4; k++) begin
        turn_q[k] <= turn_d[k];
        addr_q[k] <= addr_d[k];
        neg3_q[k] <= neg_d[k];
        neg4_q[k] <= neg3_q[k];
      end
      for (int k = 0; k < 5; k++) begin
        prod_q[k] <= prod_d[k];
        sign_q[k] <= sign_d[k];
      end
      ta_q   <= sp[0] + sp[1] + HALF_SUM;
      tb_q   <= sp[2] + sp[3];
      tc_q   <= sp[4];
      tab_q  <= ta_q + tb_q;
      tc7_q  <= tc_q;
      sum_q  <= tab_q + tc7_q;
      coef_q <= (COEF_FRAC_BITS + 2)'(val);
    end
  end

  assign tag_o  = tag_q[8];
  assign coef_o = coef_q;

endmodule

FILE: design/window_coefficient_generator_top.sv
// The block takes one item per cycle while in_stall_o is low.
// The divider, which forms the phase or the Welch value, is a 33-stage bit-serial pipeline.
// The output register and a skid stage let the pipeline run on after an output stall.
// in_stall_o rises only while the skid stage holds a result; the whole pipeline then holds.
// Reset (asynchronous, active low) clears all valid bits and loads window type rectangle and
// window size 1024.
module window_coefficient_generator_top #(
  parameter int unsigned INDEX_BITS     = wcg_pkg::INDEX_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = wcg_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned COS_TABLE_BITS = wcg_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wcg_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [wcg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [INDEX_BITS-1:0]              sample_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [COEF_FRAC_BITS+1:0]   coefficient_o,
  output logic                               index_error_o
);
  import wcg_pkg::*;

  localparam int unsigned QW    = COEF_FRAC_BITS + 2;
  localparam int unsigned CMP_W = (INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W;
  localparam int unsigned XW    = 2 * SIZE_W + COEF_FRAC_BITS + 2;

  logic [TYPE_W-1:0]   window_type_q;
  logic [SIZE_W-1:0]   window_size_q;
  logic [2*SIZE_W-1:0] den_q;
  logic [DIV_RW-1:0]   divisor_q;

  wcg_tag_t            tag_s1_q, tag_s2_q, tag_s3_q;
  logic [SIZE_W-1:0]   idx_s1_q, idx_s2_q;
  logic [2*SIZE_W-1:0] prod_s2_q;
  logic [DIV_RW-1:0]   rem_s3_q;
  logic [DIV_QW-1:0]   bits_s3_q;

  wcg_tag_t            div_tag;
  logic [DIV_QW-1:0]   div_quo;
  wcg_tag_t            last_tag;
  logic signed [COEF_FRAC_BITS+1:0] last_coef;

  logic                out_valid_q, skid_valid_q;
  logic signed [COEF_FRAC_BITS+1:0] out_coef_q, skid_coef_q;
  logic                out_err_q, skid_err_q;

  logic                en;
  logic                welch;
  logic                in_err;
  logic [SIZE_W-1:0]   in_idx;
  logic [SIZE_W-1:0]   diff;
  logic [XW-1:0]       x_w;
  logic [DIV_RW-1:0]   rem_d;
  logic [DIV_QW-1:0]   bits_d;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign welch      = window_type_q == TYPE_WELCH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_type_q <= TYPE_RESET;
      window_size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_TYPE: window_type_q <= cfg_wdata_i[TYPE_W-1:0];
        REG_WINDOW_SIZE: window_size_q <= cfg_wdata_i[SIZE_W-1:0];
        default:         window_type_q <= window_type_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    den_q     <= (2 * SIZE_W)'(window_size_q) * (2 * SIZE_W)'(window_size_q);
    divisor_q <= welch ? {den_q, 1'b0} : DIV_RW'(window_size_q);
  end

  assign in_err = CMP_W'(sample_index_i) >= CMP_W'(window_size_q);
  assign in_idx = in_err ? '0 : SIZE_W'(sample_index_i);
  assign diff   = window_size_q - idx_s1_q;

  assign x_w = (XW'({prod_s2_q[2*SIZE_W-3:0], 2'b00}) << (COEF_FRAC_BITS + 1)) + XW'(den_q);

  always_comb begin
    if (welch) begin
      rem_d  = DIV_RW'(x_w[XW-1:QW]);
      bits_d = {x_w[QW-1:0], {(DIV_QW - QW){1'b0}}};
    end else begin
      rem_d  = DIV_RW'(idx_s2_q);
      bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_s1_q <= '0;
      tag_s2_q <= '0;
      tag_s3_q <= '0;
    end else if (en) begin
      tag_s1_q <= '{valid: in_valid_i, err: in_err};
      tag_s2_q <= tag_s1_q;
      tag_s3_q <= tag_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_s1_q  <= in_idx;
      idx_s2_q  <= idx_s1_q;
      prod_s2_q <= (2 * SIZE_W)'(idx_s1_q) * (2 * SIZE_W)'(diff);
      rem_s3_q  <= rem_d;
      bits_s3_q <= bits_d;
    end
  end

  wcg_div_pipe #(
    .QW(DIV_QW),
    .RW(DIV_RW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .tag_i    (tag_s3_q),
    .rem_i    (rem_s3_q),
    .bits_i   (bits_s3_q),
    .divisor_i(divisor_q),
    .tag_o    (div_tag),
    .quo_o    (div_quo)
  );

  wcg_post #(
    .COS_TABLE_BITS(COS_TABLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .window_type_i(window_type_q),
    .tag_i        (div_tag),
    .quo_i        (div_quo),
    .tag_o        (last_tag),
    .coef_o       (last_coef)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q || last_tag.valid;
      skid_valid_q <= 1'b0;
    end else if (en && last_tag.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_coef_q <= skid_coef_q;
        out_err_q  <= skid_err_q;
      end else begin
        out_coef_q <= last_coef;
        out_err_q  <= last_tag.err;
      end
    end else if (en) begin
      skid_coef_q <= last_coef;
      skid_err_q  <= last_tag.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = out_coef_q;
  assign index_error_o = out_err_q;

endmodule

FILE: design/wcg_checker.sv
// Port-level checker for the window coefficient generator and its bind statement.
`include "assert_macros.svh"

module wcg_port_checker #(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_i,
  input logic                             out_valid_i,
  input logic                             out_stall_i,
  input logic signed [COEF_FRAC_BITS+1:0] coefficient_i,
  input logic                             index_error_i
);

  `ASSERT_NEVER(a_err_zero, clk_i, rst_ni, out_valid_i && index_error_i && coefficient_i != '0, "Flagged index with nonzero coefficient.")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i && $stable(coefficient_i) && $stable(index_error_i), "Stalled result changed.")
  `ASSERT_CLK(a_skid_full, clk_i, rst_ni, in_stall_i |-> out_valid_i, "Input stalled with no pending result.")
  `ASSERT_CLK(a_skid_drain, clk_i, rst_ni, in_stall_i && !out_stall_i |=> !in_stall_i, "Skid stage did not drain.")

endmodule

bind window_coefficient_generator_top wcg_port_checker #(
  .COEF_FRAC_BITS(COEF_FRAC_BITS)
) u_wcg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .coefficient_i(coefficient_o),
  .index_error_i(index_error_o)
);

FILE: bench/wcg_checker.sv
// Checker that predicts each window coefficient and compares it with the block's output.
`timescale 1ns / 100ps

module wcg_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wcg_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [wcg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [15:0]                     sample_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic signed [17:0]              coefficient_i,
  input  logic                            index_error_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct packed {
    logic signed [17:0] coef;
    logic               err;
  } coef_result_t;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;

  logic [wcg_pkg::TYPE_W-1:0] win_type;
  logic [wcg_pkg::SIZE_W-1:0] win_size;
  logic [63:0]                cos_rom [0:1024];
  coef_result_t               expected_q [$];

  function automatic logic [63:0] q30_ratio(input logic [63:0] num, input logic [63:0] den);
    return ((num << 31) + den) / (64'd2 * den);
  endfunction

  function automatic logic [63:0] cos_weight(input logic [3:0] wt, input int k);
    logic [63:0] nums [5];
    logic [63:0] den;
    nums = '{default: 64'd0};
    den  = 64'd1;
    case (wt)
      4'd0: nums[0] = 64'd1;
      4'd1: begin nums = '{25, 21, 0, 0, 0}; den = 46; end
      4'd2: begin nums = '{1, 1, 0, 0, 0}; den = 2; end
      4'd3: begin nums = '{7938, 9240, 1430, 0, 0}; den = 18608; end
      4'd4: begin nums = '{355768, 487396, 144232, 12604, 0}; den = 1000000; end
      4'd5: begin nums = '{3635819, 4891775, 1365995, 106411, 0}; den = 10000000; end
      4'd6: begin nums = '{35875, 48829, 14128, 1168, 0}; den = 100000; end
      4'd7: begin
        nums = '{215578950, 416631580, 277263158, 83578947, 6947368};
        den  = 1000000000;
      end
      default: ;
    endcase
    if (wt == 4'd0 && k == 0) return Q30_ONE;
    if (wt == 4'd2 && k < 2) return Q30_ONE / 2;
    return q30_ratio(nums[k], den);
  endfunction

  function automatic logic [63:0] taylor_cos(input int unsigned j);
    logic [63:0] x;
    logic [63:0] xsq;
    logic [63:0] t;
    longint      acc;
    x   = (64'd1686629713 * 64'(j) + 64'd512) >> 10;
    xsq = (x * x) >> 30;
    t   = Q30_ONE;
    acc = longint'(Q30_ONE);
    for (int n = 1; n <= 12; n++) begin
      t = ((t * xsq) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(Q30_ONE)) acc = longint'(Q30_ONE);
    return 64'(acc);
  endfunction

  function automatic longint cos_turn(input logic [31:0] turn);
    logic [63:0] idx;
    logic [9:0]  r;
    idx = ((64'(turn) + 64'd524288) >> 20) & 64'hFFF;
    r   = idx[9:0];
    case (idx[11:10])
      2'd0: return longint'(cos_rom[r]);
      2'd1: return -longint'(cos_rom[1024 - r]);
      2'd2: return -longint'(cos_rom[r]);
      default: return longint'(cos_rom[1024 - r]);
    endcase
  endfunction

  function automatic coef_result_t predict_coefficient(input logic [15:0] sidx);
    coef_result_t res;
    logic [63:0]  i;
    logic [63:0]  n;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  w;
    logic [63:0]  u;
    logic [31:0]  ph;
    longint       acc;
    longint       val;
    i   = 64'(sidx);
    n   = 64'(win_size);
    val = 0;
    res.err = 1'b0;
    if (i >= n) begin
      res.coef = '0;
      res.err  = 1'b1;
      return res;
    end
    if (win_type == wcg_pkg::TYPE_WELCH) begin
      num = 64'd4 * i * (n - i);
      den = n * n;
      val = longint'(((num << 17) + den) / (64'd2 * den));
    end else if (win_type < wcg_pkg::TYPE_WELCH) begin
      ph  = 32'((((i << 33) / n) + 64'd1) >> 1);
      acc = 0;
      for (int k = 0; k < 5; k++) begin
        w = cos_weight(win_type, k);
        if (w != 0) begin
          if (k % 2 == 1) acc -= longint'(w) * cos_turn(32'(64'(k) * 64'(ph)));
          else acc += longint'(w) * cos_turn(32'(64'(k) * 64'(ph)));
        end
      end
      u   = (64'(acc + (longint'(1) << 62)) + (64'd1 << 43)) >> 44;
      val = longint'(u) - (longint'(1) << 18);
    end
    if (val > 131071) val = 131071;
    if (val < -131072) val = -131072;
    res.coef = 18'(val);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    for (int j = 0; j <= 1024; j++) cos_rom[j] = taylor_cos(j);
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    coef_result_t exp_res;
    if (!rst_ni) begin
      win_type = wcg_pkg::TYPE_RESET;
      win_size = wcg_pkg::SIZE_RESET;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("output transfer with nothing expected");
        end else begin
          exp_res = expected_q.pop_front();
          if (coefficient_i !== exp_res.coef)
            report_mismatch($sformatf("coefficient %0d, expected %0d",
                                      coefficient_i, exp_res.coef));
          if (index_error_i !== exp_res.err)
            report_mismatch($sformatf("index_error %0b, expected %0b",
                                      index_error_i, exp_res.err));
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_coefficient(sample_index_i));
      if (cfg_we_i) begin
        if (cfg_index_i == wcg_pkg::REG_WINDOW_TYPE) win_type = cfg_wdata_i[3:0];
        else if (cfg_index_i == wcg_pkg::REG_WINDOW_SIZE) win_size = cfg_wdata_i;
      end
    end
  end

endmodule

FILE: bench/tb.sv
// Top of the window coefficient generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [wcg_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [wcg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [15:0]                     sample_index_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic signed [17:0]              coefficient_o;
  logic                            index_error_o;
  int                              fail_count;
  int                              pending;
  int                              idle_cycles = 0;
  int                              stall_left = 0;
  bit                              gaps_on = 1'b1;
  logic [16:0]                     cur_size = 17'd1024;

  always #10 clk_i = ~clk_i;

  window_coefficient_generator_top dut (.*);

  wcg_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .sample_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .coefficient_i(coefficient_o),
    .index_error_i(index_error_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[window_coefficient_generator_top] ERROR");
      $finish;
    end
  end

  task automatic send_index(input logic [15:0] sidx);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_index_i <= sidx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wcg_pkg::CFG_INDEX_W-1:0] ridx,
                           input logic [16:0] wdata);
    in_valid_i  <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ridx;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (ridx == wcg_pkg::REG_WINDOW_SIZE) cur_size = wdata;
  endtask

  task automatic set_window(input logic [3:0] wt, input logic [16:0] sz);
    write_reg(wcg_pkg::REG_WINDOW_TYPE, 17'(wt));
    write_reg(wcg_pkg::REG_WINDOW_SIZE, sz);
  endtask

  function automatic logic [15:0] pick_index();
    if (cur_size == 0 || $urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    if (cur_size > 65536) return 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) == 0) return 16'(cur_size - 1);
    return 16'($urandom_range(0, cur_size - 1));
  endfunction

  initial begin
    logic [16:0] sz;
    logic [3:0]  wt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_index(16'd0);
    send_index(16'd1023);
    send_index(16'd1024);
    send_index(16'hFFFF);
    set_window(4'd2, 17'd8);
    for (int k = 0; k <= 8; k++) send_index(16'(k));
    set_window(wcg_pkg::TYPE_WELCH, 17'h10000);
    send_index(16'd0);
    send_index(16'h8000);
    send_index(16'hFFFF);
    set_window(4'd7, 17'd1024);
    send_index(16'd0);
    send_index(16'd512);
    set_window(4'd15, 17'd16);
    send_index(16'd3);
    send_index(16'd16);
    set_window(4'd6, 17'd0);
    send_index(16'd0);
    set_window(4'd1, 17'd1);
    send_index(16'd0);
    send_index(16'd1);

    for (int ph = 0; ph < 28; ph++) begin
      gaps_on = (ph % 5 != 3);
      wt = (ph < 9) ? 4'(ph) : ($urandom_range(0, 7) == 0 ? 4'($urandom_range(9, 15))
                                                          : 4'($urandom_range(0, 8)));
      case ($urandom_range(0, 9))
        0: sz = 17'h10000;
        1: sz = 17'hFFFF;
        2: sz = 17'd1;
        3: sz = $urandom_range(0, 1) ? 17'd0 : 17'($urandom_range(1, 131071));
        4: sz = 17'($urandom_range(1, 65536));
        default: sz = 17'($urandom_range(2, 300));
      endcase
      set_window(wt, sz);
      repeat (62) send_index(pick_index());
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[window_coefficient_generator_top] OK");
    end else begin
      $display("[window_coefficient_generator_top] ERROR");
    end
    $finish;
  end

endmodule
